// ===== hdl/tlbpt_pkg.sv =====
// Shared widths, default sizes and control types for the TLB page table translator.
`default_nettype none

package tlbpt_pkg;

   localparam int VA_W        = 16;
   localparam int PA_W        = 16;
   localparam int FRAME_OUT_W = 8;
   localparam int COUNT_W     = 32;

   localparam int TLB_DEPTH_DEFAULT   = 16;
   localparam int PAGE_COUNT_DEFAULT  = 256;
   localparam int FRAME_COUNT_DEFAULT = 256;
   localparam int OFFSET_BITS_DEFAULT = 8;

   typedef struct packed {
      logic clear;
      logic capture;
      logic finish;
   } tlbpt_cmd_type;

   typedef struct packed {
      logic clear_last;
   } tlbpt_status_type;

endpackage

`default_nettype wire

// ===== hdl/tlbpt_if.sv =====
// Valid/ready channel interfaces for the translator's request and response items.
`default_nettype none

interface tlbpt_req_if;
   import tlbpt_pkg::*;

   logic            valid;
   logic            ready;
   logic [VA_W-1:0] virtual_address;

   modport source (output valid, output virtual_address, input ready);
   modport sink   (input valid, input virtual_address, output ready);
endinterface

interface tlbpt_rsp_if;
   import tlbpt_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [PA_W-1:0]        physical_address;
   logic [FRAME_OUT_W-1:0] frame_index;
   logic                   tlb_hit;
   logic                   page_fault;
   logic                   out_of_frames;
   logic [COUNT_W-1:0]     hit_count;
   logic [COUNT_W-1:0]     fault_count;
   logic [COUNT_W-1:0]     translation_count;

   modport source (output valid, output physical_address, output frame_index,
                   output tlb_hit, output page_fault, output out_of_frames,
                   output hit_count, output fault_count, output translation_count,
                   input ready);
   modport sink   (input valid, input physical_address, input frame_index,
                   input tlb_hit, input page_fault, input out_of_frames,
                   input hit_count, input fault_count, input translation_count,
                   output ready);
endinterface

`default_nettype wire

// ===== hdl/tlbpt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tlbpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/tlbpt_ctrl.sv =====
// Controller state machine: page table clearing, item capture, lookup completion.
`default_nettype none

module tlbpt_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output tlbpt_pkg::tlbpt_cmd_type         cmd,
   input  wire tlbpt_pkg::tlbpt_status_type status
);
   import tlbpt_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_LOOKUP = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      rsp_valid_in = cmd.finish | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== hdl/tlbpt_datapath.sv =====
// Datapath: page split, TLB entries, page table RAM, frame allocation and counters.
`default_nettype none

module tlbpt_datapath #(
   parameter int TLB_DEPTH   = tlbpt_pkg::TLB_DEPTH_DEFAULT,
   parameter int PAGE_COUNT  = tlbpt_pkg::PAGE_COUNT_DEFAULT,
   parameter int FRAME_COUNT = tlbpt_pkg::FRAME_COUNT_DEFAULT,
   parameter int OFFSET_BITS = tlbpt_pkg::OFFSET_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire tlbpt_pkg::tlbpt_cmd_type             cmd,
   output tlbpt_pkg::tlbpt_status_type               status,
   input  wire logic [tlbpt_pkg::VA_W-1:0]           req_virtual_address,
   output logic      [tlbpt_pkg::PA_W-1:0]           rsp_physical_address,
   output logic      [tlbpt_pkg::FRAME_OUT_W-1:0]    rsp_frame_index,
   output logic                                      rsp_tlb_hit,
   output logic                                      rsp_page_fault,
   output logic                                      rsp_out_of_frames,
   output logic      [tlbpt_pkg::COUNT_W-1:0]        rsp_hit_count,
   output logic      [tlbpt_pkg::COUNT_W-1:0]        rsp_fault_count,
   output logic      [tlbpt_pkg::COUNT_W-1:0]        rsp_translation_count
);
   import tlbpt_pkg::*;

   localparam int VPN_W     = (VA_W > OFFSET_BITS) ? VA_W - OFFSET_BITS : 1;
   localparam int PAGE_W    = $clog2(PAGE_COUNT);
   localparam int RED_W     = (VPN_W + 1 > PAGE_W) ? VPN_W + 1 : PAGE_W;
   localparam int RED_STEPS = (VPN_W + 1 > PAGE_W) ? VPN_W + 1 - PAGE_W : 0;
   localparam int FRAME_W   = $clog2(FRAME_COUNT);
   localparam int NF_W      = $clog2(FRAME_COUNT + 1);
   localparam int TP_W      = $clog2(TLB_DEPTH);
   localparam int ENTRY_W   = FRAME_W + 1;
   localparam int PHYS_W    = VA_W + FRAME_W;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] value);
      return (value == '1) ? value : value + COUNT_W'(1);
   endfunction

   // The page number is reduced modulo the page count by conditional subtraction.
   logic [VA_W-1:0]   va_shift;
   logic [RED_W-1:0]  red_val;
   logic [PAGE_W-1:0] req_page;

   always_comb begin
      va_shift = req_virtual_address >> OFFSET_BITS;
      red_val  = RED_W'(va_shift[VPN_W-1:0]);
      for (int k = RED_STEPS - 1; k >= 0; k--) begin
         if (red_val >= RED_W'(PAGE_COUNT << k)) begin
            red_val = red_val - RED_W'(PAGE_COUNT << k);
         end
      end
      req_page = red_val[PAGE_W-1:0];
   end

   logic [PAGE_W-1:0]      page_ff;
   logic [OFFSET_BITS-1:0] offset_ff;

   logic [PAGE_W-1:0]  tlb_tag_ff   [TLB_DEPTH];
   logic [FRAME_W-1:0] tlb_frame_ff [TLB_DEPTH];
   logic [TLB_DEPTH-1:0] tlb_valid_ff, tlb_valid_in;
   logic [TP_W-1:0]    tlb_ptr_ff, tlb_ptr_in;
   logic [NF_W-1:0]    next_free_ff, next_free_in;
   logic [COUNT_W-1:0] hit_total_ff, hit_total_in;
   logic [COUNT_W-1:0] fault_total_ff, fault_total_in;
   logic [COUNT_W-1:0] trans_total_ff, trans_total_in;
   logic [PAGE_W-1:0]  clear_addr_ff, clear_addr_in;

   logic               ram_wr_en;
   logic [PAGE_W-1:0]  ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic [ENTRY_W-1:0] ram_rd_data;

   tlbpt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (PAGE_COUNT)
   ) u_page_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.capture),
      .rd_addr (req_page),
      .rd_data (ram_rd_data)
   );

   logic [TLB_DEPTH-1:0] tlb_match;
   logic                 tlb_hit;
   logic [FRAME_W-1:0]   tlb_frame;

   always_comb begin
      tlb_frame = '0;
      for (int i = 0; i < TLB_DEPTH; i++) begin
         tlb_match[i] = tlb_valid_ff[i] && (tlb_tag_ff[i] == page_ff);
         tlb_frame    = tlb_frame | (tlb_match[i] ? tlb_frame_ff[i] : '0);
      end
      tlb_hit = |tlb_match;
   end

   logic               pt_valid;
   logic [FRAME_W-1:0] pt_frame;
   logic               can_alloc;
   logic [FRAME_W-1:0] lk_frame;
   logic               lk_have, lk_fault, lk_full, lk_fill, lk_alloc;
   logic [PA_W-1:0]    lk_phys;

   assign pt_valid  = ram_rd_data[FRAME_W];
   assign pt_frame  = ram_rd_data[FRAME_W-1:0];
   assign can_alloc = next_free_ff < NF_W'(FRAME_COUNT);

   always_comb begin
      lk_frame = '0;
      lk_have  = 1'b0;
      lk_fault = 1'b0;
      lk_full  = 1'b0;
      lk_fill  = 1'b0;
      lk_alloc = 1'b0;
      priority if (tlb_hit) begin
         lk_frame = tlb_frame;
         lk_have  = 1'b1;
      end else if (pt_valid) begin
         lk_frame = pt_frame;
         lk_have  = 1'b1;
         lk_fill  = 1'b1;
      end else if (can_alloc) begin
         lk_frame = next_free_ff[FRAME_W-1:0];
         lk_have  = 1'b1;
         lk_fault = 1'b1;
         lk_fill  = 1'b1;
         lk_alloc = 1'b1;
      end else begin
         lk_full = 1'b1;
      end
      lk_phys = lk_have
              ? PA_W'((PHYS_W'(lk_frame) << OFFSET_BITS) | PHYS_W'(offset_ff))
              : '0;
   end

   always_comb begin
      ram_wr_en   = cmd.clear | (cmd.finish & lk_alloc);
      ram_wr_addr = cmd.clear ? clear_addr_ff : page_ff;
      ram_wr_data = cmd.clear ? '0 : {1'b1, lk_frame};
   end

   always_comb begin
      tlb_valid_in   = tlb_valid_ff;
      tlb_ptr_in     = tlb_ptr_ff;
      next_free_in   = next_free_ff;
      hit_total_in   = hit_total_ff;
      fault_total_in = fault_total_ff;
      trans_total_in = trans_total_ff;
      clear_addr_in  = cmd.clear ? PAGE_W'(clear_addr_ff + 1'b1) : clear_addr_ff;
      if (cmd.finish) begin
         trans_total_in = sat_inc(trans_total_ff);
         if (tlb_hit) begin
            hit_total_in = sat_inc(hit_total_ff);
         end
         if (!tlb_hit && !pt_valid) begin
            fault_total_in = sat_inc(fault_total_ff);
         end
         if (lk_fill) begin
            tlb_valid_in[tlb_ptr_ff] = 1'b1;
            tlb_ptr_in = (tlb_ptr_ff == TP_W'(TLB_DEPTH - 1)) ? '0
                       : TP_W'(tlb_ptr_ff + 1'b1);
         end
         if (lk_alloc) begin
            next_free_in = NF_W'(next_free_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tlb_valid_ff   <= '0;
         tlb_ptr_ff     <= '0;
         next_free_ff   <= '0;
         hit_total_ff   <= '0;
         fault_total_ff <= '0;
         trans_total_ff <= '0;
         clear_addr_ff  <= '0;
      end else begin
         tlb_valid_ff   <= tlb_valid_in;
         tlb_ptr_ff     <= tlb_ptr_in;
         next_free_ff   <= next_free_in;
         hit_total_ff   <= hit_total_in;
         fault_total_ff <= fault_total_in;
         trans_total_ff <= trans_total_in;
         clear_addr_ff  <= clear_addr_in;
      end
   end

   logic [PA_W-1:0]        rsp_phys_ff;
   logic [FRAME_OUT_W-1:0] rsp_frame_ff;
   logic                   rsp_hit_ff, rsp_fault_ff, rsp_full_ff;
   logic [COUNT_W-1:0]     rsp_hits_ff, rsp_faults_ff, rsp_trans_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         page_ff   <= req_page;
         offset_ff <= req_virtual_address[OFFSET_BITS-1:0];
      end
      if (cmd.finish && lk_fill) begin
         tlb_tag_ff[tlb_ptr_ff]   <= page_ff;
         tlb_frame_ff[tlb_ptr_ff] <= lk_frame;
      end
      if (cmd.finish) begin
         rsp_phys_ff   <= lk_phys;
         rsp_frame_ff  <= FRAME_OUT_W'(lk_frame);
         rsp_hit_ff    <= tlb_hit;
         rsp_fault_ff  <= lk_fault;
         rsp_full_ff   <= lk_full;
         rsp_hits_ff   <= hit_total_in;
         rsp_faults_ff <= fault_total_in;
         rsp_trans_ff  <= trans_total_in;
      end
   end

   assign status.clear_last     = clear_addr_ff == PAGE_W'(PAGE_COUNT - 1);
   assign rsp_physical_address  = rsp_phys_ff;
   assign rsp_frame_index       = rsp_frame_ff;
   assign rsp_tlb_hit           = rsp_hit_ff;
   assign rsp_page_fault        = rsp_fault_ff;
   assign rsp_out_of_frames     = rsp_full_ff;
   assign rsp_hit_count         = rsp_hits_ff;
   assign rsp_fault_count       = rsp_faults_ff;
   assign rsp_translation_count = rsp_trans_ff;

endmodule

`default_nettype wire

// ===== hdl/tlb_page_table_translator.sv =====
// Top level of the TLB page table translator.
`default_nettype none

// Translates one virtual address per item into a physical frame address through a
// fully associative TLB backed by a demand-paged page table held in RAM. Each item
// passes through a capture step, which captures the address and reads the page table
// entry, then a lookup step, which compares the TLB tags, allocates a frame on a page
// fault and writes the new entry. The single page table RAM port pair sets this split.
// After reset the block clears every page table entry, with req_if.ready low. A
// finished result waits in an output register while the next item is accepted; a
// lookup holds in its lookup step while the previous result has not been taken.
module tlb_page_table_translator #(
   parameter int TLB_DEPTH   = tlbpt_pkg::TLB_DEPTH_DEFAULT,
   parameter int PAGE_COUNT  = tlbpt_pkg::PAGE_COUNT_DEFAULT,
   parameter int FRAME_COUNT = tlbpt_pkg::FRAME_COUNT_DEFAULT,
   parameter int OFFSET_BITS = tlbpt_pkg::OFFSET_BITS_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   tlbpt_req_if.sink   req_if,
   tlbpt_rsp_if.source rsp_if
);
   import tlbpt_pkg::*;

   tlbpt_cmd_type    cmd;
   tlbpt_status_type status;

   tlbpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .status    (status)
   );

   tlbpt_datapath #(
      .TLB_DEPTH   (TLB_DEPTH),
      .PAGE_COUNT  (PAGE_COUNT),
      .FRAME_COUNT (FRAME_COUNT),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_virtual_address   (req_if.virtual_address),
      .rsp_physical_address  (rsp_if.physical_address),
      .rsp_frame_index       (rsp_if.frame_index),
      .rsp_tlb_hit           (rsp_if.tlb_hit),
      .rsp_page_fault        (rsp_if.page_fault),
      .rsp_out_of_frames     (rsp_if.out_of_frames),
      .rsp_hit_count         (rsp_if.hit_count),
      .rsp_fault_count       (rsp_if.fault_count),
      .rsp_translation_count (rsp_if.translation_count)
   );

endmodule

`default_nettype wire

// ===== sim/tlb_page_table_translator_tb.sv =====
// Self-checking testbench for tlb_page_table_translator with predicted translations.
module tlb_page_table_translator_tb;
   import tlbpt_pkg::*;

   localparam int TLB_DEPTH          = TLB_DEPTH_DEFAULT;
   localparam int FRAME_COUNT        = FRAME_COUNT_DEFAULT;
   localparam int OFFSET_BITS        = OFFSET_BITS_DEFAULT;
   localparam int PAGE_W             = VA_W - OFFSET_BITS;
   localparam int RESULT_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT     = 4000;
   localparam int REPORT_LIMIT       = 10;

   typedef struct packed {
      logic [PA_W-1:0]        physical_address;
      logic [FRAME_OUT_W-1:0] frame_index;
      logic                   tlb_hit;
      logic                   page_fault;
      logic                   out_of_frames;
      logic [COUNT_W-1:0]     hit_count;
      logic [COUNT_W-1:0]     fault_count;
      logic [COUNT_W-1:0]     translation_count;
   } translation_type;

   logic clock;
   logic reset;

   tlbpt_req_if req_if ();
   tlbpt_rsp_if rsp_if ();

   tlb_page_table_translator dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   logic [PAGE_W-1:0]      tlb_tag       [TLB_DEPTH];
   logic [FRAME_OUT_W-1:0] tlb_frame     [TLB_DEPTH];
   logic                   tlb_live      [TLB_DEPTH]    = '{default: 1'b0};
   logic [$clog2(TLB_DEPTH)-1:0] tlb_fill_slot         = '0;
   logic [FRAME_OUT_W-1:0] page_frame    [1 << PAGE_W];
   logic                   page_present  [1 << PAGE_W]  = '{default: 1'b0};
   logic [FRAME_OUT_W:0]   next_free_frame              = '0;
   logic [COUNT_W-1:0]     hit_total                    = '0;
   logic [COUNT_W-1:0]     fault_total                  = '0;
   logic [COUNT_W-1:0]     translation_total            = '0;

   translation_type expected_translations [$];
   int           mismatch_count = 0;
   int           result_index   = 0;
   int           idle_pct       = 36;
   int           stalled_cycles = 0;
   bit           hold_results   = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [COUNT_W-1:0] saturating_increment(input logic [COUNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic translation_type translate_address(input logic [VA_W-1:0] va);
      logic [PAGE_W-1:0]      page;
      logic [FRAME_OUT_W-1:0] frame;
      logic                   hit;
      logic                   refill;
      int                     i;
      translation_type        r;
      page   = va[VA_W-1:OFFSET_BITS];
      frame  = '0;
      hit    = 1'b0;
      refill = 1'b0;
      r      = '0;
      translation_total = saturating_increment(translation_total);
      for (i = 0; i < TLB_DEPTH; i++) begin
         if (!hit && tlb_live[i] && tlb_tag[i] == page) begin
            hit   = 1'b1;
            frame = tlb_frame[i];
         end
      end
      if (hit) begin
         hit_total = saturating_increment(hit_total);
      end else if (page_present[page]) begin
         frame  = page_frame[page];
         refill = 1'b1;
      end else begin
         fault_total = saturating_increment(fault_total);
         if (next_free_frame < FRAME_COUNT) begin
            frame              = next_free_frame[FRAME_OUT_W-1:0];
            next_free_frame    = next_free_frame + 1'b1;
            page_frame[page]   = frame;
            page_present[page] = 1'b1;
            refill             = 1'b1;
            r.page_fault       = 1'b1;
         end else begin
            r.out_of_frames = 1'b1;
         end
      end
      if (refill) begin
         tlb_tag[tlb_fill_slot]   = page;
         tlb_frame[tlb_fill_slot] = frame;
         tlb_live[tlb_fill_slot]  = 1'b1;
         tlb_fill_slot            = tlb_fill_slot + 1'b1;
      end
      if (!r.out_of_frames) begin
         r.physical_address = {frame, va[OFFSET_BITS-1:0]};
         r.frame_index      = frame;
      end
      r.tlb_hit           = hit;
      r.hit_count         = hit_total;
      r.fault_count       = fault_total;
      r.translation_count = translation_total;
      return r;
   endfunction

   function automatic string describe(input translation_type t);
      return $sformatf("pa=%h frame=%h hit=%b fault=%b oof=%b hits=%0d faults=%0d xlat=%0d",
                       t.physical_address, t.frame_index, t.tlb_hit, t.page_fault,
                       t.out_of_frames, t.hit_count, t.fault_count, t.translation_count);
   endfunction

   task automatic issue_address(input logic [VA_W-1:0] va);
      if ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.virtual_address <= va;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      expected_translations.push_back(translate_address(va));
   endtask

   task automatic wait_for_drain;
      req_if.valid <= 1'b0;
      while (expected_translations.size() != 0) @(posedge clock);
   endtask

   task automatic test_address_extremes;
      issue_address(16'h0000);
      issue_address(16'h00FF);
      issue_address(16'hFFFF);
      issue_address(16'hFF00);
      issue_address(16'h8001);
      issue_address(16'h7FFE);
   endtask

   // Seventeen fresh pages push the first one out of the TLB, so it returns from the page table.
   task automatic test_tlb_refill_order;
      int n;
      for (n = 0; n < 17; n++) begin
         issue_address({PAGE_W'(8'h10 + n), OFFSET_BITS'($urandom_range(255))});
      end
      issue_address({PAGE_W'(8'h10), OFFSET_BITS'(8'h5A)});
      issue_address({PAGE_W'(8'h20), OFFSET_BITS'(8'hA5)});
   endtask

   task automatic test_random_traffic(input int count);
      logic [PAGE_W-1:0] hot_pages    [8];
      logic [PAGE_W-1:0] recent_pages [32];
      logic [PAGE_W-1:0] page;
      int                roll;
      int                n;
      foreach (hot_pages[i]) hot_pages[i] = PAGE_W'($urandom_range(255));
      foreach (recent_pages[i]) recent_pages[i] = PAGE_W'($urandom_range(255));
      for (n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 45) begin
            page = hot_pages[$urandom_range(7)];
         end else if (roll < 70) begin
            page = recent_pages[$urandom_range(31)];
         end else begin
            page = PAGE_W'($urandom_range(255));
         end
         recent_pages[n % 32] = page;
         if ($urandom_range(63) == 0) begin
            hot_pages[$urandom_range(7)] = page;
         end
         issue_address({page, OFFSET_BITS'($urandom_range(255))});
      end
   endtask

   task automatic test_output_stall;
      int n;
      hold_results = 1'b1;
      for (n = 0; n < 24; n++) begin
         issue_address(VA_W'($urandom_range(16'hFFFF)));
      end
   endtask

   task automatic test_pause_until_drained;
      test_random_traffic(20);
      wait_for_drain();
      test_random_traffic(20);
   endtask

   task automatic test_back_to_back;
      idle_pct = 0;
      test_random_traffic(400);
      idle_pct = 36;
   endtask

   initial begin
      int hold_left;
      hold_left    = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_results) begin
            hold_results = 1'b0;
            hold_left    = RESULT_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      translation_type got;
      translation_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got = {rsp_if.physical_address, rsp_if.frame_index, rsp_if.tlb_hit,
                rsp_if.page_fault, rsp_if.out_of_frames, rsp_if.hit_count,
                rsp_if.fault_count, rsp_if.translation_count};
         if (expected_translations.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("result %0d arrived with nothing expected: %s",
                        result_index, describe(got));
            end
         end else begin
            want = expected_translations.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("result %0d mismatch", result_index);
                  $display("   expected %s", describe(want));
                  $display("   actual   %s", describe(got));
               end
            end
         end
         result_index++;
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
      end
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      reset                  = 1'b1;
      req_if.valid           = 1'b0;
      req_if.virtual_address = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_address_extremes();
      test_tlb_refill_order();
      test_random_traffic(600);
      test_output_stall();
      test_pause_until_drained();
      test_back_to_back();
      test_random_traffic(700);
      wait_for_drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
